// ===== hw/rtl/hthc_pkg.sv =====
// ----------------------------------------------------------------------------
// hthc_pkg: shared types and constants of the hall throttle conditioner
// Field widths, calibration defaults, register map, sequencer states and the
// request struct of the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package hthc_pkg;

    localparam int DATA_W  = 10;
    localparam int SUM_W   = 13;
    localparam int CNT_W   = 3;
    localparam int NUM_W   = 2 * DATA_W;
    localparam int STEP_W  = $clog2(NUM_W);
    localparam int ADDR_W  = 4;
    localparam int PDATA_W = 32;

    localparam int unsigned GROUP_SIZE    = 5;
    localparam int unsigned NEUTRAL_LEVEL = 512;
    localparam int unsigned FULL_SCALE    = 1023;

    // group mean as a reciprocal multiply: floor(sum * MEAN_RECIP >> MEAN_SHIFT)
    localparam int MEAN_SHIFT = 16;
    localparam int RECIP_W    = MEAN_SHIFT + 1;
    localparam logic [RECIP_W-1:0] MEAN_RECIP =
        RECIP_W'(((1 << MEAN_SHIFT) + GROUP_SIZE - 1) / GROUP_SIZE);

    localparam logic [DATA_W-1:0] NEUTRAL    = DATA_W'(NEUTRAL_LEVEL);
    localparam logic [DATA_W-1:0] FULL       = DATA_W'(FULL_SCALE);
    localparam logic [DATA_W-1:0] UPPER_GAIN = DATA_W'(FULL_SCALE - NEUTRAL_LEVEL);
    localparam logic [DATA_W-1:0] LOWER_GAIN = DATA_W'(NEUTRAL_LEVEL);

    localparam logic [DATA_W-1:0] RST_CAL_MIN    = DATA_W'(0);
    localparam logic [DATA_W-1:0] RST_CAL_CENTER = DATA_W'(512);
    localparam logic [DATA_W-1:0] RST_CAL_MAX    = DATA_W'(1023);
    localparam logic [DATA_W-1:0] RST_DEAD_BAND  = DATA_W'(0);

    typedef enum logic [1:0] {
        REG_CAL_MIN,
        REG_CAL_CENTER,
        REG_CAL_MAX,
        REG_DEAD_BAND
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN,
        ST_SETUP,
        ST_MUL,
        ST_MAP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] cal_min;
        logic [DATA_W-1:0] cal_center;
        logic [DATA_W-1:0] cal_max;
        logic [DATA_W-1:0] dead_band;
    } cal_regs_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hall_throttle_conditioner_core.sv =====
// ----------------------------------------------------------------------------
// hall_throttle_conditioner_core: hall sensor throttle conditioner
// Sequencing: a sample that does not close a group is taken with no result; a
//   closing sample runs the mean, setup, multiply, map and finish states (map
//   skipped when the active calibration span is zero), then waits for output.
// Busy: no new sample is taken until the closing sample's result is loaded;
//   the map is one 20-step pass through the shared radix-2 divider and the
//   group mean is a single reciprocal multiply.
// Reset: synchronous active-low aresetn clears the group sum, count, filter,
//   sequencer and output valid, and loads the calibration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module hall_throttle_conditioner_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // sample input channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [hthc_pkg::DATA_W-1:0]    s_sample,
    // result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [hthc_pkg::DATA_W-1:0]    m_throttle_level,
    output logic      [hthc_pkg::DATA_W-1:0]    m_smoothed_hall,
    output logic      [hthc_pkg::DATA_W-1:0]    m_group_mean,
    // calibration register port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hthc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [hthc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [hthc_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);

    localparam int DW = hthc_pkg::DATA_W;
    localparam int NW = hthc_pkg::NUM_W;
    localparam int PW = hthc_pkg::SUM_W + hthc_pkg::RECIP_W;

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    hthc_pkg::cal_regs_t cal;

    hthc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cal     (cal)
    );

    // zero-wait-state register access
    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // Shared divider: calibration map
    // ------------------------------------------------------------------
    hthc_pkg::div_req_t  div_req;
    logic                div_done;
    logic [NW-1:0]       div_quo;

    hthc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    hthc_pkg::state_t state_reg, state_next;

    logic [hthc_pkg::SUM_W-1:0] sum_reg;
    logic [hthc_pkg::CNT_W-1:0] count_reg;
    logic [DW-1:0]              filter_reg;
    logic [DW-1:0]              mean_reg;
    logic                       upper_reg;
    logic signed [DW:0]         diff_reg;
    logic signed [DW:0]         span_reg;
    logic                       neg_reg;
    logic                       zero_reg;
    logic [NW-1:0]              quo_reg;

    logic                       m_valid_reg;
    logic [DW-1:0]              thr_reg;
    logic [DW-1:0]              smooth_reg;
    logic [DW-1:0]              gmean_reg;

    // control decoded from the state
    logic s_ready_int;
    logic out_load;

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    logic                       s_xfer;
    logic [hthc_pkg::SUM_W-1:0] sum_next;
    logic [hthc_pkg::CNT_W-1:0] count_next;
    logic                       group_done;
    logic                       out_free;

    logic [PW-1:0]              mean_prod;
    logic [DW-1:0]              mean_q;
    logic [DW+1:0]              filt_sum;
    logic [DW-1:0]              filter_next;

    logic                       upper_next;
    logic signed [DW:0]         diff_next;
    logic signed [DW:0]         span_next;

    logic [DW:0]                diff_abs;
    logic [DW:0]                span_abs;
    logic [DW-1:0]              gain;
    logic [NW-1:0]              prod;
    logic                       span_zero;

    logic [DW-1:0]              up_level;
    logic [DW-1:0]              lo_level;
    logic [DW-1:0]              level;
    logic [DW-1:0]              neutral_gap;
    logic [DW-1:0]              thr_next;

    assign s_xfer     = s_valid & s_ready_int;
    assign sum_next   = sum_reg + hthc_pkg::SUM_W'(s_sample);
    assign count_next = count_reg + hthc_pkg::CNT_W'(1);
    assign group_done = (count_next == hthc_pkg::CNT_W'(hthc_pkg::GROUP_SIZE));
    assign out_free   = !m_valid_reg || m_ready;

    // group mean from the held closing sum by a reciprocal multiply
    assign mean_prod = PW'(sum_reg) * PW'(hthc_pkg::MEAN_RECIP);
    assign mean_q    = mean_prod[hthc_pkg::MEAN_SHIFT +: DW];

    // exponential filter: (3 * mean + old) >> 2
    assign filt_sum    = {2'b00, mean_q} + {1'b0, mean_q, 1'b0} + {2'b00, filter_reg};
    assign filter_next = filt_sum[DW+1:2];

    // branch select and signed offsets around the calibrated center
    assign upper_next = (filter_reg >= cal.cal_center);
    assign diff_next  = upper_next
                        ? $signed({1'b0, filter_reg}) - $signed({1'b0, cal.cal_center})
                        : $signed({1'b0, filter_reg}) - $signed({1'b0, cal.cal_min});
    assign span_next  = upper_next
                        ? $signed({1'b0, cal.cal_max}) - $signed({1'b0, cal.cal_center})
                        : $signed({1'b0, cal.cal_center}) - $signed({1'b0, cal.cal_min});

    // magnitudes for the unsigned divider; the sign is carried separately
    assign diff_abs  = diff_reg[DW] ? (~diff_reg + 1'b1) : diff_reg;
    assign span_abs  = span_reg[DW] ? (~span_reg + 1'b1) : span_reg;
    assign gain      = upper_reg ? hthc_pkg::UPPER_GAIN : hthc_pkg::LOWER_GAIN;
    assign prod      = diff_abs[DW-1:0] * gain;
    assign span_zero = (span_reg == '0);

    // clamp into the branch range; a negative quotient lands on the low end
    assign up_level = (quo_reg > NW'(hthc_pkg::UPPER_GAIN))
                      ? hthc_pkg::FULL
                      : hthc_pkg::NEUTRAL + quo_reg[DW-1:0];
    assign lo_level = (quo_reg > NW'(hthc_pkg::NEUTRAL))
                      ? hthc_pkg::NEUTRAL
                      : quo_reg[DW-1:0];

    always_comb begin
        if (zero_reg) begin
            level = upper_reg ? hthc_pkg::FULL : '0;
        end else if (upper_reg) begin
            level = neg_reg ? hthc_pkg::NEUTRAL : up_level;
        end else begin
            level = neg_reg ? '0 : lo_level;
        end
    end

    // snap to neutral inside the dead band
    assign neutral_gap = (level >= hthc_pkg::NEUTRAL) ? (level - hthc_pkg::NEUTRAL)
                                                      : (hthc_pkg::NEUTRAL - level);
    assign thr_next    = (neutral_gap < cal.dead_band) ? hthc_pkg::NEUTRAL : level;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hthc_pkg::ST_IDLE: begin
                if (s_xfer && group_done) begin
                    state_next = hthc_pkg::ST_MEAN;
                end
            end
            hthc_pkg::ST_MEAN: begin
                state_next = hthc_pkg::ST_SETUP;
            end
            hthc_pkg::ST_SETUP: begin
                state_next = hthc_pkg::ST_MUL;
            end
            hthc_pkg::ST_MUL: begin
                state_next = span_zero ? hthc_pkg::ST_FINISH : hthc_pkg::ST_MAP;
            end
            hthc_pkg::ST_MAP: begin
                if (div_done) begin
                    state_next = hthc_pkg::ST_FINISH;
                end
            end
            hthc_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = hthc_pkg::ST_IDLE;
                end
            end
            default: state_next = hthc_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready_int      = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = prod;
        div_req.divisor  = span_abs[DW-1:0];
        case (state_reg)
            hthc_pkg::ST_IDLE: begin
                s_ready_int = 1'b1;
            end
            hthc_pkg::ST_MUL: begin
                // launch the map division unless the span is empty
                div_req.start = !span_zero;
            end
            hthc_pkg::ST_FINISH: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hthc_pkg::ST_IDLE;
            sum_reg     <= '0;
            count_reg   <= '0;
            filter_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // accumulate the group, hold the closing sum for the mean, then drop it
            if (s_xfer) begin
                sum_reg   <= sum_next;
                count_reg <= group_done ? '0 : count_next;
            end else if (state_reg == hthc_pkg::ST_MEAN) begin
                sum_reg <= '0;
            end
            if (state_reg == hthc_pkg::ST_MEAN) begin
                filter_reg <= filter_next;
            end
            // hold the result until the transfer, then free the slot
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == hthc_pkg::ST_MEAN) begin
            mean_reg <= mean_q;
        end
        if (state_reg == hthc_pkg::ST_SETUP) begin
            upper_reg <= upper_next;
            diff_reg  <= diff_next;
            span_reg  <= span_next;
        end
        if (state_reg == hthc_pkg::ST_MUL) begin
            neg_reg  <= diff_reg[DW] ^ span_reg[DW];
            zero_reg <= span_zero;
        end
        if (state_reg == hthc_pkg::ST_MAP && div_done) begin
            quo_reg <= div_quo;
        end
        if (out_load) begin
            thr_reg    <= thr_next;
            smooth_reg <= filter_reg;
            gmean_reg  <= mean_reg;
        end
    end

    assign s_ready          = s_ready_int;
    assign m_valid          = m_valid_reg;
    assign m_throttle_level = thr_reg;
    assign m_smoothed_hall  = smooth_reg;
    assign m_group_mean     = gmean_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hthc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hthc_cfg_regs: calibration register file
// APB-style write and read access to the four calibration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hthc_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hthc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [hthc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [hthc_pkg::PDATA_W-1:0]   prdata,
    output hthc_pkg::cal_regs_t                 cal
);

    hthc_pkg::cal_regs_t cal_reg;
    hthc_pkg::reg_idx_t  idx;
    logic                wr_en;
    logic [hthc_pkg::DATA_W-1:0] wr_val;

    assign idx    = hthc_pkg::reg_idx_t'(paddr[hthc_pkg::ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign wr_val = pwdata[hthc_pkg::DATA_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg.cal_min    <= hthc_pkg::RST_CAL_MIN;
            cal_reg.cal_center <= hthc_pkg::RST_CAL_CENTER;
            cal_reg.cal_max    <= hthc_pkg::RST_CAL_MAX;
            cal_reg.dead_band  <= hthc_pkg::RST_DEAD_BAND;
        end else if (wr_en) begin
            case (idx)
                hthc_pkg::REG_CAL_MIN:    cal_reg.cal_min    <= wr_val;
                hthc_pkg::REG_CAL_CENTER: cal_reg.cal_center <= wr_val;
                hthc_pkg::REG_CAL_MAX:    cal_reg.cal_max    <= wr_val;
                hthc_pkg::REG_DEAD_BAND:  cal_reg.dead_band  <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            hthc_pkg::REG_CAL_MIN:    prdata = hthc_pkg::PDATA_W'(cal_reg.cal_min);
            hthc_pkg::REG_CAL_CENTER: prdata = hthc_pkg::PDATA_W'(cal_reg.cal_center);
            hthc_pkg::REG_CAL_MAX:    prdata = hthc_pkg::PDATA_W'(cal_reg.cal_max);
            hthc_pkg::REG_DEAD_BAND:  prdata = hthc_pkg::PDATA_W'(cal_reg.dead_band);
            default:                  prdata = '0;
        endcase
    end

    assign cal = cal_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hthc_divider.sv =====
// ----------------------------------------------------------------------------
// hthc_divider: shared radix-2 restoring divider
// Unsigned NUM_W-bit dividend over DATA_W-bit nonzero divisor, one quotient
// bit per cycle; done pulses for one cycle once the quotient is complete.
// ----------------------------------------------------------------------------
`default_nettype none

module hthc_divider (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  hthc_pkg::div_req_t                req,
    output logic                              done,
    output logic      [hthc_pkg::NUM_W-1:0]   quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [hthc_pkg::STEP_W-1:0]   step_reg;
    logic [hthc_pkg::NUM_W-1:0]    quo_reg;
    logic [hthc_pkg::DATA_W-1:0]   rem_reg;
    logic [hthc_pkg::DATA_W-1:0]   dvs_reg;
    logic [hthc_pkg::DATA_W:0]     shifted;
    logic [hthc_pkg::DATA_W:0]     diff;
    logic                          fits;

    // shift in the next dividend bit and try the subtraction
    assign shifted = {rem_reg, quo_reg[hthc_pkg::NUM_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == hthc_pkg::STEP_W'(hthc_pkg::NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + hthc_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[hthc_pkg::DATA_W-1:0] : shifted[hthc_pkg::DATA_W-1:0];
            quo_reg <= {quo_reg[hthc_pkg::NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hthc_checker.sv =====
// ----------------------------------------------------------------------------
// hthc_checker: port-level checks of the hall throttle conditioner
// Watches the sample and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hthc_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [hthc_pkg::DATA_W-1:0] m_throttle_level,
    input wire logic [hthc_pkg::DATA_W-1:0] m_smoothed_hall,
    input wire logic [hthc_pkg::DATA_W-1:0] m_group_mean
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_throttle_level)
            && $stable(m_smoothed_hall) && $stable(m_group_mean))
        else $error("result changed while stalled");

    // input goes busy only after a sample transfer
    a_busy_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_ready))
        else $error("input went busy without a transfer");

    // a new result only comes out of a busy period
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while idle");

    // reset leaves the block idle and empty
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not clear the block");

endmodule

bind hall_throttle_conditioner_core hthc_checker u_hthc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_throttle_level (m_throttle_level),
    .m_smoothed_hall  (m_smoothed_hall),
    .m_group_mean     (m_group_mean)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hall_throttle_conditioner_core
// Streams raw hall samples through the sample channel, predicts every group
// result (mean, smoothed value, mapped throttle) and checks it field by field
// against the result channel. Calibration is rewritten between phases through
// the register port, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    // Signed copies of the map constants. The package versions are unsigned,
    // and mixing them into the signed map arithmetic would make it unsigned.
    localparam int SCALE_TOP   = int'(hthc_pkg::FULL_SCALE);
    localparam int NEUTRAL_MID = int'(hthc_pkg::NEUTRAL_LEVEL);
    localparam int SETTLE      = 60;    // cycles to let the core go idle
    localparam int HOLD_LEN    = 600;   // long receiver hold-off
    localparam int NUM_PHASES  = 8;
    localparam int GROUPS_PER  = 30;
    localparam int LOG_LIMIT   = 20;

    typedef struct packed {
        logic [hthc_pkg::DATA_W-1:0] throttle;
        logic [hthc_pkg::DATA_W-1:0] smoothed;
        logic [hthc_pkg::DATA_W-1:0] mean;
    } hall_result_t;

    // ------------------------------------------------------------------------
    // Core ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                           aclk    = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [hthc_pkg::DATA_W-1:0]    s_sample = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [hthc_pkg::DATA_W-1:0]    m_throttle_level;
    logic [hthc_pkg::DATA_W-1:0]    m_smoothed_hall;
    logic [hthc_pkg::DATA_W-1:0]    m_group_mean;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [hthc_pkg::ADDR_W-1:0]    paddr   = '0;
    logic [hthc_pkg::PDATA_W-1:0]   pwdata  = '0;
    logic [hthc_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    hall_throttle_conditioner_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_throttle_level (m_throttle_level),
        .m_smoothed_hall  (m_smoothed_hall),
        .m_group_mean     (m_group_mean),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic [hthc_pkg::DATA_W-1:0] sample_backlog[$];   // samples waiting for the driver
    hall_result_t                expected_results[$]; // predicted results, oldest first

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit sample_taken   = 1'b0;   // a sample transfer happened at the last edge

    // Long receiver hold-off: the stimulus side flips hold_kick, the counter
    // process below owns hold_left.
    bit hold_kick = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    int mismatches       = 0;
    int samples_accepted = 0;
    int results_checked  = 0;
    int settings_applied = 0;

    // Predictor state: group accumulator, filter and calibration copy
    logic [hthc_pkg::SUM_W-1:0]  group_sum   = '0;
    logic [hthc_pkg::CNT_W-1:0]  group_count = '0;
    logic [hthc_pkg::DATA_W-1:0] filter_q    = '0;
    hthc_pkg::cal_regs_t         cal_model   = '{cal_min:    hthc_pkg::RST_CAL_MIN,
                                                 cal_center: hthc_pkg::RST_CAL_CENTER,
                                                 cal_max:    hthc_pkg::RST_CAL_MAX,
                                                 dead_band:  hthc_pkg::RST_DEAD_BAND};

    // ------------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------------
    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Piecewise map around the calibrated center, truncating toward zero,
    // then clamp to the branch range and snap inside the dead band.
    function automatic logic [hthc_pkg::DATA_W-1:0] map_throttle(
        input logic [hthc_pkg::DATA_W-1:0] hall);
        int x, c, lo, hi, t, d;
        x  = int'(hall);
        c  = int'(cal_model.cal_center);
        lo = int'(cal_model.cal_min);
        hi = int'(cal_model.cal_max);
        if (x >= c) begin
            // zero upper span saturates to full scale
            if (hi == c) t = SCALE_TOP;
            else t = (x - c) * (SCALE_TOP - NEUTRAL_MID) / (hi - c) + NEUTRAL_MID;
            if (t < NEUTRAL_MID) t = NEUTRAL_MID;
            if (t > SCALE_TOP)   t = SCALE_TOP;
        end else begin
            // zero lower span saturates to the bottom
            if (lo == c) t = 0;
            else t = (x - lo) * NEUTRAL_MID / (c - lo);
            if (t < 0)           t = 0;
            if (t > NEUTRAL_MID) t = NEUTRAL_MID;
        end
        d = (t >= NEUTRAL_MID) ? t - NEUTRAL_MID : NEUTRAL_MID - t;
        if (d < int'(cal_model.dead_band)) t = NEUTRAL_MID;
        return hthc_pkg::DATA_W'(t);
    endfunction

    // Add one sample to the open group; return 1 with the result when the
    // sample closes the group.
    function automatic bit absorb_sample(input logic [hthc_pkg::DATA_W-1:0] s,
                                         output hall_result_t r);
        logic [hthc_pkg::DATA_W-1:0] mean;
        r           = '0;
        group_sum   = group_sum + hthc_pkg::SUM_W'(s);
        group_count = group_count + hthc_pkg::CNT_W'(1);
        if (int'(group_count) < int'(hthc_pkg::GROUP_SIZE)) return 1'b0;
        mean        = hthc_pkg::DATA_W'(int'(group_sum) / int'(hthc_pkg::GROUP_SIZE));
        group_sum   = '0;
        group_count = '0;
        filter_q    = hthc_pkg::DATA_W'((3 * int'(mean) + int'(filter_q)) >> 2);
        r.throttle  = map_throttle(filter_q);
        r.smoothed  = filter_q;
        r.mean      = mean;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [hthc_pkg::DATA_W-1:0] got,
                                   input logic [hthc_pkg::DATA_W-1:0] want);
        mismatches++;
        if (mismatches <= LOG_LIMIT)
            $display("tb: %0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Edge sampling: check results, predict accepted samples
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        hall_result_t want;
        sample_taken = aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_throttle_level, '0);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (m_throttle_level !== want.throttle)
                    report_mismatch("throttle_level", m_throttle_level, want.throttle);
                if (m_smoothed_hall !== want.smoothed)
                    report_mismatch("smoothed_hall", m_smoothed_hall, want.smoothed);
                if (m_group_mean !== want.mean)
                    report_mismatch("group_mean", m_group_mean, want.mean);
            end
        end
        if (sample_taken) begin
            samples_accepted++;
            if (absorb_sample(s_sample, want)) expected_results.push_back(want);
        end
    end

    // ------------------------------------------------------------------------
    // Sample driver: hold the payload until transfer, then advance or idle
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || sample_taken) begin
            if (sample_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid  <= 1'b1;
                s_sample <= sample_backlog.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, forced low during a hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hold-off counter: restart on each kick, count down one per cycle
    always @(posedge aclk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_LEN;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // One register write: setup cycle, access cycle, done when pready is seen.
    // Upper data bits carry junk; only the low field is kept.
    task automatic write_calibration(input hthc_pkg::reg_idx_t idx,
                                     input logic [hthc_pkg::DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {(hthc_pkg::PDATA_W - hthc_pkg::DATA_W)'($urandom()), value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            hthc_pkg::REG_CAL_MIN:    cal_model.cal_min    = value;
            hthc_pkg::REG_CAL_CENTER: cal_model.cal_center = value;
            hthc_pkg::REG_CAL_MAX:    cal_model.cal_max    = value;
            hthc_pkg::REG_DEAD_BAND:  cal_model.dead_band  = value;
            default: ;
        endcase
        @(negedge aclk);
        // the addressed register now reads back the kept field
        if (prdata !== hthc_pkg::PDATA_W'(value))
            report_mismatch("prdata", prdata[hthc_pkg::DATA_W-1:0], value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_calibration(input int lo, input int mid, input int hi, input int band);
        write_calibration(hthc_pkg::REG_CAL_MIN,    hthc_pkg::DATA_W'(lo));
        write_calibration(hthc_pkg::REG_CAL_CENTER, hthc_pkg::DATA_W'(mid));
        write_calibration(hthc_pkg::REG_CAL_MAX,    hthc_pkg::DATA_W'(hi));
        write_calibration(hthc_pkg::REG_DEAD_BAND,  hthc_pkg::DATA_W'(band));
        settings_applied++;
    endtask

    // Wait for the backlog to drain and every result to arrive, then give the
    // core time to finish any trailing work before the next register write.
    task automatic drain_and_settle();
        while (sample_backlog.size() > 0 || s_valid) @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic int pick_end_value();
        case ($urandom_range(2))
            0:       return 0;
            1:       return SCALE_TOP;
            default: return int'($urandom_range(0, SCALE_TOP));
        endcase
    endfunction

    // Random calibration: well-formed, fully random, or built from extremes
    task automatic random_calibration(input int kind);
        int mid;
        case (kind)
            0: begin
                mid = int'($urandom_range(100, 923));
                apply_calibration(int'($urandom_range(0, mid - 1)), mid,
                                  int'($urandom_range(mid + 1, SCALE_TOP)),
                                  int'($urandom_range(0, 64)));
            end
            1: apply_calibration(int'($urandom_range(0, SCALE_TOP)),
                                 int'($urandom_range(0, SCALE_TOP)),
                                 int'($urandom_range(0, SCALE_TOP)),
                                 int'($urandom_range(0, SCALE_TOP)));
            default: apply_calibration(pick_end_value(), pick_end_value(),
                                       pick_end_value(),
                                       $urandom_range(3) == 0 ? SCALE_TOP :
                                       int'($urandom_range(0, 32)));
        endcase
    endtask

    // Queue sample groups. Most are steady levels with jitter aimed at the
    // calibration points, so the filter settles where the map is interesting;
    // the rest are noise, rail-to-rail extremes, and broken short groups.
    task automatic queue_groups(input int n_groups);
        int lvl, jit, v, n;
        for (int g = 0; g < n_groups; g++) begin
            n   = int'(hthc_pkg::GROUP_SIZE);
            jit = int'($urandom_range(0, 12));
            case ($urandom_range(4))
                0: lvl = int'(cal_model.cal_center) + int'($urandom_range(0, 80)) - 40;
                1: lvl = int'(cal_model.cal_min) + int'($urandom_range(0, 40)) - 20;
                2: lvl = int'(cal_model.cal_max) + int'($urandom_range(0, 40)) - 20;
                default: lvl = int'($urandom_range(0, SCALE_TOP));
            endcase
            case ($urandom_range(9))
                0, 1: jit = SCALE_TOP * 2;          // plain noise
                8:    jit = -1;                     // extremes only
                9:    n = int'($urandom_range(1, int'(hthc_pkg::GROUP_SIZE) - 1));
                default: ;
            endcase
            for (int k = 0; k < n; k++) begin
                if (jit < 0) v = $urandom_range(1) ? SCALE_TOP : 0;
                else v = lvl + int'($urandom_range(0, 2 * jit)) - jit;
                if (v < 0) v = 0;
                if (v > SCALE_TOP) v = SCALE_TOP;
                sample_backlog.push_back(hthc_pkg::DATA_W'(v));
            end
        end
    endtask

    task automatic queue_fixed(input int a, input int b, input int c, input int d,
                               input int e);
        sample_backlog.push_back(hthc_pkg::DATA_W'(a));
        sample_backlog.push_back(hthc_pkg::DATA_W'(b));
        sample_backlog.push_back(hthc_pkg::DATA_W'(c));
        sample_backlog.push_back(hthc_pkg::DATA_W'(d));
        sample_backlog.push_back(hthc_pkg::DATA_W'(e));
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Reset calibration: one full-scale group.
        queue_fixed(SCALE_TOP, SCALE_TOP, SCALE_TOP, SCALE_TOP, SCALE_TOP);
        drain_and_settle();

        // Zero upper span: everything lands on the upper branch, saturate high.
        apply_calibration(0, 0, 0, 0);
        queue_fixed(0, SCALE_TOP, 512, 1, 1022);
        drain_and_settle();

        // Zero lower span: everything below the top sits on the lower branch.
        apply_calibration(SCALE_TOP, SCALE_TOP, SCALE_TOP, 0);
        queue_fixed(0, 0, 1, 0, 0);
        drain_and_settle();

        // Inverted calibration on both branches, signed truncating map.
        apply_calibration(SCALE_TOP, 512, 0, 0);
        queue_fixed(SCALE_TOP, 700, 900, SCALE_TOP, 800);
        drain_and_settle();

        // Widest dead band: every result snaps to neutral.
        apply_calibration(0, 512, SCALE_TOP, SCALE_TOP);
        queue_fixed(0, 341, 682, SCALE_TOP, 0);
        drain_and_settle();

        // Random phases: rotate through the idling modes and calibrations.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            random_calibration(p % 3);
            // Hold the receiver off for a long stretch while samples keep
            // coming, so the core backs up and stalls its input.
            if (p == 4) hold_kick = ~hold_kick;
            queue_groups(GROUPS_PER);
            drain_and_settle();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_and_settle();

        $display("tb: %0d samples in, %0d group results checked, %0d calibration settings",
                 samples_accepted, results_checked, settings_applied);
        $display("tb: idle and stall mixes, long output hold-off, zero and inverted spans");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
